@@ rtl/core/ghtr_pkg.sv @@
`default_nettype none
package ghtr_pkg;

  localparam int SLOT_COUNT_DEF     = 1024;
  localparam int MATERIAL_COUNT_DEF = 256;

  localparam logic [1:0] CMD_CREATE  = 2'd0;
  localparam logic [1:0] CMD_DESTROY = 2'd1;
  localparam logic [1:0] CMD_UPDATE  = 2'd2;
  localparam logic [1:0] CMD_QUERY   = 2'd3;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_STALE     = 3'd2;
  localparam logic [2:0] ST_NOT_ALIVE = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam int IN_BITS  = 88;
  localparam int OUT_BITS = 56;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] handle_index;
    logic [31:0] handle_generation;
    logic [31:0] material_id;
    logic        bad;
  } cmd_entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        alive;
    logic [7:0]  material_index;
    logic [31:0] material_generation;
    logic [10:0] active_count;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/generational_handle_table_refcount.sv @@
// accept to m_tvalid: an invalid handle goes straight to the result, a query or a
// stale / not-alive / same-material command after the slot read; a destroy adds a
// release, a create a search of every material entry ever allocated and an acquire,
// a rebind all three; the back end holds one item, taking the next once its result leaves
// reset: synchronous; afterwards a clearing pass over max(SLOT_COUNT,
// MATERIAL_COUNT) entries runs before the first item is taken
`default_nettype none
module generational_handle_table_refcount #(
  parameter int SLOT_COUNT     = ghtr_pkg::SLOT_COUNT_DEF,
  parameter int MATERIAL_COUNT = ghtr_pkg::MATERIAL_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // command, handle_index, handle_generation, material_id, zero pad
  input  wire logic [ghtr_pkg::IN_BITS-1:0]  s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // status, alive, material_index, material_generation, active_count, zero pad
  output logic      [ghtr_pkg::OUT_BITS-1:0] m_tdata
);
  import ghtr_pkg::*;

  cmd_entry_t q_entry;
  logic       q_valid;
  logic       q_pop;
  result_t    res;
  logic       res_valid;
  logic       res_ready;

  // front: classify and queue incoming beats
  ghtr_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop)
  );

  // back: slot and material table sequencer
  ghtr_back #(.SLOT_COUNT(SLOT_COUNT), .MATERIAL_COUNT(MATERIAL_COUNT)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop),
    .res_valid(res_valid), .res(res), .res_ready(res_ready)
  );

  // output register, refilled as soon as the held beat leaves
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {1'b0, res.active_count, res.material_generation,
                  res.material_index, res.alive, res.status};
    end
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/ghtr_ram.sv @@
`default_nettype none
module ghtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/ghtr_front.sv @@
`default_nettype none
module ghtr_front #(
  parameter int SLOT_COUNT = ghtr_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [ghtr_pkg::IN_BITS-1:0] s_tdata,
  output logic                            q_valid,
  output ghtr_pkg::cmd_entry_t            q_entry,
  input  wire logic                       q_pop
);
  import ghtr_pkg::*;

  localparam logic [16:0] SLOT_LIM = 17'(SLOT_COUNT);

  cmd_entry_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  cmd_entry_t cls;
  logic       push;

  // classify: zero generation or index past the table
  always_comb begin
    cls.command           = s_tdata[1:0];
    cls.handle_index      = s_tdata[17:2];
    cls.handle_generation = s_tdata[49:18];
    cls.material_id       = s_tdata[81:50];
    cls.bad = (s_tdata[49:18] == 32'd0) || ({1'b0, s_tdata[17:2]} >= SLOT_LIM);
  end

  assign s_tready = (cnt != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (cnt != 2'd0);
  assign q_entry  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= cls;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/ghtr_back.sv @@
`default_nettype none
module ghtr_back #(
  parameter int SLOT_COUNT     = ghtr_pkg::SLOT_COUNT_DEF,
  parameter int MATERIAL_COUNT = ghtr_pkg::MATERIAL_COUNT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire ghtr_pkg::cmd_entry_t q_entry,
  output logic                      q_pop,
  output logic                      res_valid,
  output ghtr_pkg::result_t         res,
  input  wire logic                 res_ready
);
  import ghtr_pkg::*;

  localparam int SIW   = $clog2(SLOT_COUNT);
  localparam int MIW   = $clog2(MATERIAL_COUNT);
  localparam int MCW   = $clog2(MATERIAL_COUNT + 1);
  localparam int RW    = $clog2(SLOT_COUNT + 1);
  localparam int CLR_N = (SLOT_COUNT > MATERIAL_COUNT) ? SLOT_COUNT : MATERIAL_COUNT;
  localparam int CLW   = $clog2(CLR_N);
  localparam logic [CLW:0] CLR_SLOT = (CLW + 1)'(SLOT_COUNT);
  localparam logic [CLW:0] CLR_MAT  = (CLW + 1)'(MATERIAL_COUNT);
  localparam logic [CLW-1:0] CLR_LAST = CLW'(CLR_N - 1);
  localparam logic [MCW-1:0] MAT_N  = MCW'(MATERIAL_COUNT);

  typedef struct packed {
    logic           live;
    logic [31:0]    gen;
    logic [31:0]    mid;
    logic [MIW-1:0] midx;
    logic [31:0]    mgen;
  } slot_word_t;

  typedef struct packed {
    logic          mapped;
    logic [RW-1:0] refs;
    logic [31:0]   gen;
    logic [31:0]   key;
  } mat_word_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SLOAD, S_SEARCH, S_REL_RD, S_REL_CHK,
    S_ACQ, S_ACQ_POP, S_ACQ_RD, S_SLOT_WR, S_DONE
  } state_t;

  state_t         st;
  cmd_entry_t     it;
  slot_word_t     s;
  slot_word_t     n;
  logic [2:0]     status;
  logic [RW-1:0]  live_total;
  logic [MCW-1:0] fd;
  logic [MCW-1:0] hw;
  logic [CLW-1:0] clr;
  logic [MCW-1:0] k;
  logic           pend;
  logic [MIW-1:0] chk;
  logic           found;
  logic [MIW-1:0] f_idx;
  logic [31:0]    f_gen;
  logic [RW-1:0]  f_refs;
  logic [MIW-1:0] e_idx;

  logic           slot_we;
  logic [SIW-1:0] slot_waddr;
  slot_word_t     slot_wdata;
  logic [SIW-1:0] slot_raddr;
  slot_word_t     slot_rd;
  logic           mat_we;
  logic [MIW-1:0] mat_waddr;
  mat_word_t      mat_wdata;
  logic [MIW-1:0] mat_raddr;
  mat_word_t      m_rd;
  logic           fs_we;
  logic [MIW-1:0] fs_waddr;
  logic [MIW-1:0] fs_raddr;
  logic [MIW-1:0] fs_rd;

  logic [31:0]    gdiff;
  logic           not_newer;
  logic           hit;
  logic           issue;
  logic           can_alloc;
  logic           rel_ok;
  logic           rel_free;
  logic [RW-1:0]  rel_refs;
  logic [31:0]    gen_bump;
  logic           frees;
  logic           full_upd;
  logic [MCW-1:0] fd_dec;

  ghtr_ram #(.WIDTH($bits(slot_word_t)), .DEPTH(SLOT_COUNT)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rd)
  );

  ghtr_ram #(.WIDTH($bits(mat_word_t)), .DEPTH(MATERIAL_COUNT)) u_mat (
    .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
    .raddr(mat_raddr), .rdata(m_rd)
  );

  ghtr_ram #(.WIDTH(MIW), .DEPTH(MATERIAL_COUNT)) u_free (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(s.midx),
    .raddr(fs_raddr), .rdata(fs_rd)
  );

  // wrap-around age compare of the handle against the stored generation
  assign gdiff     = it.handle_generation - slot_rd.gen;
  assign not_newer = (gdiff == 32'd0) || gdiff[31];
  assign can_alloc = (fd != '0) || (hw < MAT_N);
  assign hit       = pend && m_rd.mapped && (m_rd.key == it.material_id);
  assign issue     = (k < hw) && !hit;
  assign rel_ok    = (m_rd.gen == s.mgen) && (m_rd.refs != '0);
  assign rel_refs  = m_rd.refs - RW'(1);
  assign rel_free  = rel_ok && (rel_refs == '0);
  assign gen_bump  = ((m_rd.gen + 32'd1) == 32'd0) ? 32'd1 : m_rd.gen + 32'd1;
  assign frees     = (m_rd.gen == s.mgen) && (m_rd.refs == RW'(1));
  assign full_upd  = (it.command == CMD_UPDATE) && !found && !can_alloc && !frees;
  assign fd_dec    = fd - MCW'(1);
  assign q_pop     = (st == S_IDLE) && q_valid;

  // memory port control
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = it.handle_index[SIW-1:0];
    slot_wdata = n;
    slot_raddr = q_entry.handle_index[SIW-1:0];
    mat_we     = 1'b0;
    mat_waddr  = s.midx;
    mat_wdata  = m_rd;
    mat_raddr  = s.midx;
    fs_we      = 1'b0;
    fs_waddr   = fd[MIW-1:0];
    fs_raddr   = fd_dec[MIW-1:0];
    case (st)
      S_CLEAR: begin
        slot_we    = ({1'b0, clr} < CLR_SLOT);
        slot_waddr = clr[SIW-1:0];
        slot_wdata = '0;
        mat_we     = ({1'b0, clr} < CLR_MAT);
        mat_waddr  = clr[MIW-1:0];
        mat_wdata  = '{mapped: 1'b0, refs: '0, gen: 32'd1, key: 32'd0};
      end
      S_SEARCH: begin
        mat_raddr = k[MIW-1:0];
      end
      S_REL_CHK: begin
        if (!full_upd && rel_ok) begin
          mat_we         = 1'b1;
          mat_wdata.refs = rel_refs;
          if (rel_free) begin
            mat_wdata.mapped = 1'b0;
            mat_wdata.gen    = gen_bump;
          end
          fs_we = rel_free && (fd < MAT_N);
        end
      end
      S_ACQ: begin
        if (found) begin
          mat_we    = 1'b1;
          mat_waddr = f_idx;
          mat_wdata = '{mapped: 1'b1, refs: f_refs + RW'(1), gen: f_gen,
                        key: it.material_id};
        end else begin
          mat_raddr = hw[MIW-1:0];
        end
      end
      S_ACQ_POP: begin
        mat_raddr = fs_rd;
      end
      S_ACQ_RD: begin
        mat_we    = 1'b1;
        mat_waddr = e_idx;
        mat_wdata = '{mapped: 1'b1, refs: m_rd.refs + RW'(1), gen: m_rd.gen,
                      key: it.material_id};
      end
      S_SLOT_WR: begin
        slot_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_CLEAR;
      clr        <= '0;
      fd         <= '0;
      hw         <= '0;
      live_total <= '0;
      pend       <= 1'b0;
      k          <= '0;
    end else begin
      case (st)
        S_CLEAR: begin
          clr <= clr + CLW'(1);
          if (clr == CLR_LAST) begin
            st <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            it <= q_entry;
            if (q_entry.bad) begin
              status <= ST_INVALID;
              n.live <= 1'b0;
              st     <= S_DONE;
            end else begin
              st <= S_SLOAD;
            end
          end
        end
        S_SLOAD: begin
          s      <= slot_rd;
          n      <= slot_rd;
          status <= ST_DONE;
          k      <= '0;
          pend   <= 1'b0;
          if (it.command == CMD_CREATE) begin
            if (slot_rd.live || ((slot_rd.gen != 32'd0) && not_newer)) begin
              status <= ST_STALE;
              st     <= S_DONE;
            end else begin
              st <= S_SEARCH;
            end
          end else if (!(slot_rd.live && slot_rd.gen == it.handle_generation)) begin
            status <= ST_NOT_ALIVE;
            st     <= S_DONE;
          end else begin
            case (it.command)
              CMD_DESTROY: st <= S_REL_RD;
              CMD_UPDATE:  st <= (slot_rd.mid == it.material_id) ? S_DONE : S_SEARCH;
              default:     st <= S_DONE;
            endcase
          end
        end
        S_SEARCH: begin
          if (hit || (!issue && !pend)) begin
            found  <= hit;
            f_idx  <= chk;
            f_gen  <= m_rd.gen;
            f_refs <= m_rd.refs;
            if (it.command == CMD_UPDATE) begin
              st <= S_REL_RD;
            end else if (!hit && !can_alloc) begin
              status <= ST_FULL;
              st     <= S_DONE;
            end else begin
              st <= S_ACQ;
            end
          end else begin
            if (issue) begin
              chk <= k[MIW-1:0];
              k   <= k + MCW'(1);
            end
            pend <= issue;
          end
        end
        S_REL_RD: begin
          st <= S_REL_CHK;
        end
        S_REL_CHK: begin
          if (full_upd) begin
            status <= ST_FULL;
            st     <= S_DONE;
          end else begin
            if (rel_free && (fd < MAT_N)) begin
              fd <= fd + MCW'(1);
            end
            if (it.command == CMD_DESTROY) begin
              n.live <= 1'b0;
              n.mid  <= 32'd0;
              st     <= S_SLOT_WR;
            end else begin
              st <= S_ACQ;
            end
          end
        end
        S_ACQ: begin
          if (found) begin
            n  <= '{live: 1'b1, gen: it.handle_generation, mid: it.material_id,
                    midx: f_idx, mgen: f_gen};
            st <= S_SLOT_WR;
          end else if (fd != '0) begin
            fd <= fd_dec;
            st <= S_ACQ_POP;
          end else begin
            e_idx <= hw[MIW-1:0];
            hw    <= hw + MCW'(1);
            st    <= S_ACQ_RD;
          end
        end
        S_ACQ_POP: begin
          e_idx <= fs_rd;
          st    <= S_ACQ_RD;
        end
        S_ACQ_RD: begin
          n  <= '{live: 1'b1, gen: it.handle_generation, mid: it.material_id,
                  midx: e_idx, mgen: m_rd.gen};
          st <= S_SLOT_WR;
        end
        S_SLOT_WR: begin
          if (it.command == CMD_CREATE) begin
            live_total <= live_total + RW'(1);
          end else if (it.command == CMD_DESTROY && live_total != '0) begin
            live_total <= live_total - RW'(1);
          end
          st <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res_valid                 = (st == S_DONE);
    res.status                = status;
    res.alive                 = n.live && (n.gen == it.handle_generation);
    res.material_index        = res.alive ? 8'(n.midx) : 8'd0;
    res.material_generation   = res.alive ? n.mgen : 32'd0;
    res.active_count          = 11'(live_total);
  end

  a_fd_bound: assert property (@(posedge clk) disable iff (rst) fd <= MAT_N)
    else $error("free depth past material count");
  a_hw_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> hw >= $past(hw))
    else $error("high water went down");
  a_live_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (live_total == $past(live_total) ||
                     live_total == $past(live_total) + RW'(1) ||
                     live_total == $past(live_total) - RW'(1)))
    else $error("live count jumped");
endmodule
`default_nettype wire

@@ bench/ghtr_scoreboard.sv @@
`default_nettype none
module ghtr_scoreboard (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  input  wire logic                          s_tready,
  input  wire logic [ghtr_pkg::IN_BITS-1:0]  s_tdata,
  input  wire logic                          m_tvalid,
  input  wire logic                          m_tready,
  input  wire logic [ghtr_pkg::OUT_BITS-1:0] m_tdata,
  output int                                 errors,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ghtr_pkg::*;

  localparam int NSLOT = SLOT_COUNT_DEF;
  localparam int NMAT  = MATERIAL_COUNT_DEF;

  logic        slot_on [NSLOT];
  logic [31:0] slot_g [NSLOT];
  logic [31:0] slot_mid [NSLOT];
  logic [7:0]  slot_midx [NSLOT];
  logic [31:0] slot_mgen [NSLOT];
  logic [31:0] mat_id_of [NMAT];
  logic        mat_used [NMAT];
  logic [10:0] mat_cnt [NMAT];
  logic [31:0] mat_g [NMAT];
  logic [7:0]  spare [NMAT];
  logic [8:0]  spare_depth;
  logic [8:0]  mat_top;
  logic [10:0] live_slots;

  result_t results_due[$];

  function automatic int lookup_material(logic [31:0] id);
    for (int i = 0; i < NMAT; i++)
      if (mat_used[i] && mat_id_of[i] == id) return i;
    return NMAT;
  endfunction

  function automatic bit room_for_material();
    return spare_depth > 0 || mat_top < NMAT;
  endfunction

  task automatic take_material(input logic [31:0] id, output logic [7:0] e_idx,
                               output logic [31:0] e_gen);
    int e;
    e = lookup_material(id);
    if (e >= NMAT) begin
      if (spare_depth > 0) begin
        spare_depth--;
        e = spare[spare_depth[7:0]];
      end else begin
        e = mat_top[7:0];
        mat_top++;
      end
      mat_used[e] = 1'b1;
      mat_id_of[e] = id;
    end
    mat_cnt[e]++;
    e_idx = e[7:0];
    e_gen = mat_g[e];
  endtask

  task automatic drop_material(input logic [7:0] e, input logic [31:0] g);
    if (mat_g[e] != g || mat_cnt[e] == 0) return;
    mat_cnt[e]--;
    if (mat_cnt[e] != 0) return;
    mat_used[e] = 1'b0;
    mat_g[e]++;
    if (mat_g[e] == 0) mat_g[e] = 1;
    if (spare_depth < NMAT) begin
      spare[spare_depth[7:0]] = e;
      spare_depth++;
    end
  endtask

  task automatic clear_tables();
    for (int i = 0; i < NSLOT; i++) begin
      slot_on[i] = 0; slot_g[i] = 0; slot_mid[i] = 0; slot_midx[i] = 0; slot_mgen[i] = 0;
    end
    for (int i = 0; i < NMAT; i++) begin
      mat_id_of[i] = 0; mat_used[i] = 0; mat_cnt[i] = 0; mat_g[i] = 1; spare[i] = 0;
    end
    spare_depth = 0;
    mat_top = 0;
    live_slots = 0;
  endtask

  // apply one command to the shadow tables and return the result beat it should give
  task automatic run_command(input logic [1:0] cmd, input logic [15:0] idx,
                             input logic [31:0] hgen, input logic [31:0] mid,
                             output result_t r);
    logic [31:0] diff;
    bit          live_now;
    bit          found;
    bit          frees;
    r = '0;
    r.status = ST_DONE;
    if (hgen == 0 || idx >= NSLOT) begin
      r.status = ST_INVALID;
    end else if (cmd == CMD_CREATE) begin
      diff = hgen - slot_g[idx];
      if (slot_on[idx] || (slot_g[idx] != 0 && (diff == 0 || diff[31]))) begin
        r.status = ST_STALE;
      end else if (lookup_material(mid) >= NMAT && !room_for_material()) begin
        r.status = ST_FULL;
      end else begin
        slot_g[idx] = hgen;
        slot_on[idx] = 1;
        slot_mid[idx] = mid;
        take_material(mid, slot_midx[idx], slot_mgen[idx]);
        live_slots++;
      end
    end else if (!(slot_on[idx] && slot_g[idx] == hgen)) begin
      r.status = ST_NOT_ALIVE;
    end else if (cmd == CMD_DESTROY) begin
      drop_material(slot_midx[idx], slot_mgen[idx]);
      slot_on[idx] = 0;
      slot_mid[idx] = 0;
      if (live_slots > 0) live_slots--;
    end else if (cmd == CMD_UPDATE && slot_mid[idx] != mid) begin
      found = lookup_material(mid) < NMAT;
      frees = mat_g[slot_midx[idx]] == slot_mgen[idx] && mat_cnt[slot_midx[idx]] == 1;
      if (!found && !room_for_material() && !frees) begin
        r.status = ST_FULL;
      end else begin
        drop_material(slot_midx[idx], slot_mgen[idx]);
        take_material(mid, slot_midx[idx], slot_mgen[idx]);
        slot_mid[idx] = mid;
      end
    end
    live_now = hgen != 0 && idx < NSLOT && slot_on[idx] && slot_g[idx] == hgen;
    r.alive = live_now;
    r.material_index = live_now ? slot_midx[idx] : 8'd0;
    r.material_generation = live_now ? slot_mgen[idx] : 32'd0;
    r.active_count = live_slots;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    result_t fresh;
    if (rst) begin
      errors = 0;
      pending = 0;
      results_due.delete();
      clear_tables();
    end else begin
      // result side first: a beat accepted at this edge cannot answer one taken now
      if (m_tvalid && m_tready) begin
        got.status              = m_tdata[2:0];
        got.alive               = m_tdata[3];
        got.material_index      = m_tdata[11:4];
        got.material_generation = m_tdata[43:12];
        got.active_count        = m_tdata[54:44];
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %h", m_tdata);
        end else begin
          want = results_due.pop_front();
          if (got.status != want.status || got.alive != want.alive ||
              got.material_index != want.material_index ||
              got.material_generation != want.material_generation ||
              got.active_count != want.active_count) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: want st=%0d al=%0d mi=%0d mg=%h n=%0d,",
                        " got st=%0d al=%0d mi=%0d mg=%h n=%0d"},
                       want.status, want.alive, want.material_index,
                       want.material_generation, want.active_count,
                       got.status, got.alive, got.material_index,
                       got.material_generation, got.active_count);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        run_command(s_tdata[1:0], s_tdata[17:2], s_tdata[49:18], s_tdata[81:50], fresh);
        results_due.insert(results_due.size(), fresh);
      end
      pending = results_due.size();
    end
  end

endmodule
`default_nettype wire

@@ bench/tb_generational_handle_table_refcount.sv @@
`default_nettype none
module tb_generational_handle_table_refcount;
  timeunit 1ns;
  timeprecision 1ps;
  import ghtr_pkg::*;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_BITS-1:0]  s_tdata;   // command, handle_index, handle_generation, material_id, pad
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_BITS-1:0] m_tdata;   // status, alive, material_index, material_generation, count, pad
  int                  errors;
  int                  pending;

  // last generation handed out per slot, so most commands name a real handle
  logic [31:0] issued_gen [SLOT_COUNT_DEF];
  bit          calm;        // no idling on either side while set
  int          results_seen;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  generational_handle_table_refcount dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  ghtr_scoreboard chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  // one command beat; valid stays high into the next beat when no gap is drawn
  task automatic send(input logic [1:0] cmd, input logic [15:0] idx,
                      input logic [31:0] hgen, input logic [31:0] mid);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, mid, hgen, idx, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // mostly well-formed handles on a small index window, some noise
  task automatic random_beat(input int idx_span, input int mid_pool);
    logic [1:0]  cmd;
    logic [15:0] idx;
    logic [31:0] hgen;
    logic [31:0] mid;
    int          pick;
    cmd  = 2'($urandom_range(0, 3));
    idx  = 16'($urandom_range(0, idx_span - 1));
    mid  = $urandom_range(0, mid_pool - 1);
    pick = $urandom_range(0, 19);
    if (cmd == CMD_CREATE) begin
      hgen = issued_gen[idx] + $urandom_range(1, 3);
      if (hgen == 0) hgen = 1;
      issued_gen[idx] = hgen;
    end else begin
      hgen = issued_gen[idx];
    end
    if (pick == 0) begin
      // anything at all, including out-of-range index bits
      idx = 16'($urandom); hgen = $urandom; mid = $urandom;
    end else if (pick == 1) begin
      hgen = 0;
    end else if (pick == 2) begin
      hgen = issued_gen[idx] - $urandom_range(0, 2);   // stale or current handle
    end else if (pick == 3) begin
      mid = $urandom;
    end
    if (idx < SLOT_COUNT_DEF && cmd == CMD_CREATE && hgen != 0 && pick != 0)
      issued_gen[idx] = hgen;
    send(cmd, idx, hgen, mid);
  endtask

  // result side: random ready gaps, plus one long hold-off mid run
  initial begin
    int gap;
    m_tready <= 1'b0;
    results_seen = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        results_seen++;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (results_seen == 700) gap = 400;   // block fills and backs up the input
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    for (int i = 0; i < SLOT_COUNT_DEF; i++) issued_gen[i] = 0;
    calm     = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: lifecycle, wrap-around generations, invalid handles, field extremes
    send(CMD_QUERY,   16'd0,     32'd1,        32'd0);
    send(CMD_CREATE,  16'd0,     32'd1,        32'd0);
    send(CMD_CREATE,  16'd0,     32'd1,        32'd7);          // already alive
    send(CMD_QUERY,   16'd0,     32'd1,        32'd0);
    send(CMD_UPDATE,  16'd0,     32'd1,        32'd0);          // same material kept
    send(CMD_UPDATE,  16'd0,     32'd1,        32'hFFFF_FFFF);
    send(CMD_CREATE,  16'd1023,  32'hFFFF_FFFF, 32'hFFFF_FFFF); // shares the entry
    send(CMD_DESTROY, 16'd1023,  32'hFFFF_FFFF, 32'd0);
    send(CMD_CREATE,  16'd1023,  32'h7FFF_FFFF, 32'd3);         // half-range away: stale
    send(CMD_CREATE,  16'd1023,  32'd1,        32'd3);          // newer across the wrap
    send(CMD_DESTROY, 16'd0,     32'd2,        32'd0);          // wrong generation
    send(CMD_DESTROY, 16'd0,     32'd1,        32'd0);
    send(CMD_DESTROY, 16'd0,     32'd1,        32'd0);          // already dead
    send(CMD_UPDATE,  16'd0,     32'd1,        32'd5);          // dead slot
    send(CMD_QUERY,   16'd1024,  32'd1,        32'd0);          // index out of range
    send(CMD_UPDATE,  16'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(CMD_CREATE,  16'd5,     32'd0,        32'd1);          // generation zero
    send(CMD_CREATE,  16'd0,     32'd1,        32'd0);          // equal to dead slot: stale
    send(CMD_CREATE,  16'd0,     32'd2,        32'hFFFF_FFFF);
    send(CMD_QUERY,   16'd1023,  32'd1,        32'd0);
    issued_gen[0]    = 32'd2;
    issued_gen[1023] = 32'd1;

    // mixed traffic on a small window
    for (int i = 0; i < 300; i++) random_beat(24, 12);

    // fill the material table with distinct ids, then rebind and tear down
    for (int i = 0; i < 280; i++) begin
      issued_gen[100 + i] = issued_gen[100 + i] + 1;
      send(CMD_CREATE, 16'(100 + i), issued_gen[100 + i], 32'h0001_0000 + i);
    end
    for (int i = 0; i < 100; i++) begin
      int j;
      j = 100 + $urandom_range(0, 279);
      send(CMD_UPDATE, 16'(j), issued_gen[j], $urandom);
    end
    // sender pause until everything outstanding has come back
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
    for (int i = 0; i < 280; i++)
      send(CMD_DESTROY, 16'(100 + i), issued_gen[100 + i], 32'd0);

    // back-to-back stretch, then idling again
    calm = 1'b1;
    for (int i = 0; i < 80; i++) random_beat(40, 20);
    calm = 1'b0;
    for (int i = 0; i < 190; i++) random_beat(64, 30);

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ generational_handle_table_refcount.f @@
rtl/core/ghtr_pkg.sv
rtl/core/ghtr_ram.sv
rtl/core/ghtr_front.sv
rtl/core/ghtr_back.sv
rtl/core/generational_handle_table_refcount.sv
bench/ghtr_scoreboard.sv
bench/tb_generational_handle_table_refcount.sv
